/* design/segment_box_clip_top_assert.svh */
// Assertion macros for the segment clipper top level.
// Both expect aclk and aresetn in scope.
`ifndef SEGMENT_BOX_CLIP_TOP_ASSERT_SVH
`define SEGMENT_BOX_CLIP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sbc_pkg.sv */
`timescale 1ns / 1ps

package sbc_pkg;

    // default coordinate format, signed Q16.16
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // tolerance register
    localparam int EPS_BITS = 16;
    localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd66;

    // a product above 2^PROD_LIMIT_LOG puts the point out of reach
    localparam int PROD_LIMIT_LOG = 62;

endpackage

/* design/segment_box_clip_top.sv */
// Segment to box clipper, fully pipelined: one request per cycle while the skid is free.
// Default coordinates are signed Q16.16; the path runs through the bit-per-stage parameter
// dividers and the five-stage point multipliers.
// Throughput: one request per cycle with skid free; two-entry output (register plus skid).
// Reset: synchronous active-low aresetn clears all valid bits and sets epsilon to 66.
`timescale 1ns / 1ps
`include "segment_box_clip_top_assert.svh"

module segment_box_clip_top import sbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_W  = ((8 * COORD_BITS - 2 + 7) / 8) * 8,
    localparam int OUT_W = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [EPS_BITS-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, box_origin_x, box_origin_y,
    // box_width, box_height, zero pad
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y, zero pad
    output logic [OUT_W-1:0]    m_tdata,
    // clip_valid
    output logic                m_tuser
);

    localparam int C       = COORD_BITS;
    localparam int VW      = C + 1;
    localparam int NW      = C + 2;
    localparam int WW      = C + 3;
    localparam int RW      = ((C > FRAC_BITS + 2) ? C : FRAC_BITS + 2) + 2;
    localparam int DIV_LAT = (NW - 1) + FRAC_BITS + 2;
    localparam int MUL_LAT = 5;

    typedef struct packed {
        logic signed [C-1:0] sx, sy, ex, ey, ox, oy;
        logic [C-2:0]        w, h;
    } seg_t;

    typedef struct packed {
        seg_t                 seg;
        logic signed [VW-1:0] vx, vy;
        logic                 nearx, neary, hit_axis;
    } prep_t;

    typedef struct packed {
        seg_t                seg;
        logic signed [C-1:0] t0, t1;
        logic                short_seg, axis, hit_axis;
    } side_t;

    typedef struct packed {
        logic signed [C-1:0] sx, sy, ex, ey;
        logic signed [C-1:0] px0, py0, px1, py1;
        logic                short_seg, swp, in0, in1, t0neg, t0pos, t1neg, t1pos;
    } hit_t;

    typedef struct packed {
        logic signed [C-1:0] sx, sy, ex, ey;
        logic                valid;
    } res_t;

    // true if p lies within e of [lo, lo+len]
    function automatic logic within_span(input logic signed [C-1:0] p,
                                         input logic signed [C-1:0] lo,
                                         input logic [C-2:0] len,
                                         input logic [EPS_BITS-1:0] e);
        logic signed [WW-1:0] pe, le, he;
        pe = WW'(p);
        le = WW'(lo) - $signed(WW'(e));
        he = WW'(lo) + $signed(WW'(len)) + $signed(WW'(e));
        return (pe >= le) && (pe <= he);
    endfunction

    // true if t lies strictly within e of [0, 1]
    function automatic logic in_range(input logic signed [C-1:0] t,
                                      input logic [EPS_BITS-1:0] e);
        logic signed [RW-1:0] te, ee, hi;
        te = RW'(t);
        ee = $signed(RW'(e));
        hi = $signed(RW'(1) << FRAC_BITS) + ee;
        return (te > -ee) && (te < hi);
    endfunction

    logic [EPS_BITS-1:0] eps_reg;
    logic                en;

    logic  in_v_reg;
    seg_t  in_seg, in_reg;

    logic                 prep_v_reg;
    prep_t                prep_next, prep_reg;
    logic signed [NW-1:0] nl_reg, nr_reg, nb_reg, nt_reg;
    logic signed [NW-1:0] nl_next, nr_next, nb_next, nt_next;
    logic [VW-1:0]        ax, ay;

    logic                d1_v;
    prep_t               d1;
    logic signed [C-1:0] tl, tr, tb, tt;

    logic                 q_v_reg;
    side_t                q_next, q_reg;
    logic signed [VW-1:0] qvx_reg, qvy_reg;
    logic signed [C-1:0]  ymin, ymax, xin, xout;

    logic                d2_v;
    side_t               d2;
    logic signed [C-1:0] px0, py0, px1, py1;
    logic                fx0, fy0, fx1, fy1;

    logic h1_v_reg;
    hit_t h1_next, h1_reg;
    logic hit;

    logic o_v_reg;
    res_t o_next, o_reg;
    logic a_in, b_in, a_neg, b_pos;

    logic m_v_reg, skid_v_reg;
    res_t m_reg, skid_reg;

    // pipeline moves while the skid entry is free
    assign en       = !skid_v_reg;
    assign s_tready = en;

    // tolerance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    // unpack the request
    always_comb begin
        in_seg.sx = s_tdata[0*C +: C];
        in_seg.sy = s_tdata[1*C +: C];
        in_seg.ex = s_tdata[2*C +: C];
        in_seg.ey = s_tdata[3*C +: C];
        in_seg.ox = s_tdata[4*C +: C];
        in_seg.oy = s_tdata[5*C +: C];
        in_seg.w  = s_tdata[6*C +: C-1];
        in_seg.h  = s_tdata[7*C-1 +: C-1];
    end

    // direction, near-axis tests and plane numerators
    always_comb begin
        prep_next.seg = in_reg;
        prep_next.vx  = VW'(in_reg.ex) - VW'(in_reg.sx);
        prep_next.vy  = VW'(in_reg.ey) - VW'(in_reg.sy);
        ax = prep_next.vx[VW-1] ? VW'(-prep_next.vx) : VW'(prep_next.vx);
        ay = prep_next.vy[VW-1] ? VW'(-prep_next.vy) : VW'(prep_next.vy);
        prep_next.nearx = (ax < VW'(eps_reg)) || (prep_next.vx == '0);
        prep_next.neary = (ay < VW'(eps_reg)) || (prep_next.vy == '0);
        prep_next.hit_axis = prep_next.nearx
            ? within_span(in_reg.sx, in_reg.ox, in_reg.w, eps_reg)
            : within_span(in_reg.sy, in_reg.oy, in_reg.h, eps_reg);
        nl_next = NW'(in_reg.ox) - NW'(in_reg.sx);
        nr_next = NW'(in_reg.ox) + $signed(NW'(in_reg.w)) - NW'(in_reg.sx);
        nb_next = NW'(in_reg.oy) - NW'(in_reg.sy);
        nt_next = NW'(in_reg.oy) + $signed(NW'(in_reg.h)) - NW'(in_reg.sy);
    end

    // plane parameters
    sbc_div_pipe #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .NUM_W(NW), .DEN_W(VW)) u_div_l (
        .aclk(aclk), .en(en), .num(nl_reg), .den(prep_reg.vx), .quot(tl)
    );
    sbc_div_pipe #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .NUM_W(NW), .DEN_W(VW)) u_div_r (
        .aclk(aclk), .en(en), .num(nr_reg), .den(prep_reg.vx), .quot(tr)
    );
    sbc_div_pipe #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .NUM_W(NW), .DEN_W(VW)) u_div_b (
        .aclk(aclk), .en(en), .num(nb_reg), .den(prep_reg.vy), .quot(tb)
    );
    sbc_div_pipe #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS), .NUM_W(NW), .DEN_W(VW)) u_div_t (
        .aclk(aclk), .en(en), .num(nt_reg), .den(prep_reg.vy), .quot(tt)
    );

    sbc_delay #(.WIDTH($bits(prep_t)), .DEPTH(DIV_LAT)) u_dly_div (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(prep_v_reg), .in_data(prep_reg),
        .out_valid(d1_v), .out_data(d1)
    );

    // entry and exit parameters
    always_comb begin
        ymin = (tb < tt) ? tb : tt;
        ymax = (tb < tt) ? tt : tb;
        xin  = (d1.vx > 0) ? tl : tr;
        xout = (d1.vx > 0) ? tr : tl;
        q_next.seg       = d1.seg;
        q_next.short_seg = d1.nearx && d1.neary;
        q_next.axis      = d1.nearx || d1.neary;
        q_next.hit_axis  = d1.hit_axis;
        if (d1.nearx) begin
            q_next.t0 = tb;
            q_next.t1 = tt;
        end else if (d1.neary) begin
            q_next.t0 = tl;
            q_next.t1 = tr;
        end else begin
            q_next.t0 = (xin > ymin) ? xin : ymin;
            q_next.t1 = (xout < ymax) ? xout : ymax;
        end
    end

    // points at both parameters
    sbc_point_mul #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_mul_x0 (
        .aclk(aclk), .en(en), .base(q_reg.seg.sx), .dir(qvx_reg), .tpar(q_reg.t0),
        .point(px0), .far(fx0)
    );
    sbc_point_mul #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_mul_y0 (
        .aclk(aclk), .en(en), .base(q_reg.seg.sy), .dir(qvy_reg), .tpar(q_reg.t0),
        .point(py0), .far(fy0)
    );
    sbc_point_mul #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_mul_x1 (
        .aclk(aclk), .en(en), .base(q_reg.seg.sx), .dir(qvx_reg), .tpar(q_reg.t1),
        .point(px1), .far(fx1)
    );
    sbc_point_mul #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_mul_y1 (
        .aclk(aclk), .en(en), .base(q_reg.seg.sy), .dir(qvy_reg), .tpar(q_reg.t1),
        .point(py1), .far(fy1)
    );

    sbc_delay #(.WIDTH($bits(side_t)), .DEPTH(MUL_LAT)) u_dly_mul (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(q_v_reg), .in_data(q_reg),
        .out_valid(d2_v), .out_data(d2)
    );

    // hit test and parameter range flags; far flags at t1 are not needed
    always_comb begin
        hit = d2.axis ? d2.hit_axis
                      : (!fx0 && !fy0 && within_span(px0, d2.seg.ox, d2.seg.w, eps_reg)
                         && within_span(py0, d2.seg.oy, d2.seg.h, eps_reg));
        h1_next.sx        = d2.seg.sx;
        h1_next.sy        = d2.seg.sy;
        h1_next.ex        = d2.seg.ex;
        h1_next.ey        = d2.seg.ey;
        h1_next.px0       = px0;
        h1_next.py0       = py0;
        h1_next.px1       = px1;
        h1_next.py1       = py1;
        h1_next.short_seg = d2.short_seg;
        h1_next.swp       = hit && (d2.t0 > d2.t1);
        h1_next.in0       = in_range(d2.t0, eps_reg);
        h1_next.in1       = in_range(d2.t1, eps_reg);
        h1_next.t0neg     = d2.t0 < 0;
        h1_next.t0pos     = d2.t0 > 0;
        h1_next.t1neg     = d2.t1 < 0;
        h1_next.t1pos     = d2.t1 > 0;
    end

    // endpoint replacement after ordering
    always_comb begin
        a_in  = !h1_reg.short_seg && (h1_reg.swp ? h1_reg.in1 : h1_reg.in0);
        b_in  = !h1_reg.short_seg && (h1_reg.swp ? h1_reg.in0 : h1_reg.in1);
        a_neg = h1_reg.swp ? h1_reg.t1neg : h1_reg.t0neg;
        b_pos = h1_reg.swp ? h1_reg.t0pos : h1_reg.t1pos;
        o_next.sx = a_in ? (h1_reg.swp ? h1_reg.px1 : h1_reg.px0) : h1_reg.sx;
        o_next.sy = a_in ? (h1_reg.swp ? h1_reg.py1 : h1_reg.py0) : h1_reg.sy;
        o_next.ex = b_in ? (h1_reg.swp ? h1_reg.px0 : h1_reg.px1) : h1_reg.ex;
        o_next.ey = b_in ? (h1_reg.swp ? h1_reg.py0 : h1_reg.py1) : h1_reg.ey;
        o_next.valid = !h1_reg.short_seg && (a_in || b_in || (a_neg && b_pos));
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg   <= 1'b0;
            prep_v_reg <= 1'b0;
            q_v_reg    <= 1'b0;
            h1_v_reg   <= 1'b0;
            o_v_reg    <= 1'b0;
        end else if (en) begin
            in_v_reg   <= s_tvalid;
            prep_v_reg <= in_v_reg;
            q_v_reg    <= d1_v;
            h1_v_reg   <= d2_v;
            o_v_reg    <= h1_v_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg   <= in_seg;
            prep_reg <= prep_next;
            nl_reg   <= nl_next;
            nr_reg   <= nr_next;
            nb_reg   <= nb_next;
            nt_reg   <= nt_next;
            q_reg    <= q_next;
            qvx_reg  <= d1.vx;
            qvy_reg  <= d1.vy;
            h1_reg   <= h1_next;
            o_reg    <= o_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_v_reg && !m_tready) begin
            if (en && o_v_reg) begin
                skid_v_reg <= 1'b1;
            end
        end else if (skid_v_reg) begin
            m_v_reg    <= 1'b1;
            skid_v_reg <= 1'b0;
        end else begin
            m_v_reg <= o_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_v_reg && !m_tready) begin
            if (en && o_v_reg) begin
                skid_reg <= o_reg;
            end
        end else if (skid_v_reg) begin
            m_reg <= skid_reg;
        end else begin
            m_reg <= o_reg;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = OUT_W'({m_reg.ey, m_reg.ex, m_reg.sy, m_reg.sx});
    assign m_tuser  = m_reg.valid;

    `SBC_ASSERT_NOW(a_skid_behind_out, skid_v_reg, m_v_reg, "skid entry full with output empty")
    `SBC_ASSERT_NEXT(a_out_kept, m_v_reg && !m_tready, m_v_reg, "stalled output result lost")
    `SBC_ASSERT_NEXT(a_skid_kept, skid_v_reg && !m_tready, skid_v_reg, "skid result lost")

endmodule

/* design/sbc_delay.sv */
`timescale 1ns / 1ps

module sbc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    logic             v_reg [0:DEPTH-1];
    logic [WIDTH-1:0] d_reg [0:DEPTH-1];

    // valid bits, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // payload taps
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                d_reg[i] <= d_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[DEPTH-1];
    assign out_data  = d_reg[DEPTH-1];

endmodule

/* design/sbc_div_pipe.sv */
`timescale 1ns / 1ps

module sbc_div_pipe import sbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int NUM_W      = COORD_BITS + 2,
    parameter int DEN_W      = COORD_BITS + 1
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [NUM_W-1:0]      num,
    input  logic signed [DEN_W-1:0]      den,
    output logic signed [COORD_BITS-1:0] quot
);

    localparam int NM = NUM_W - 1;
    localparam int DM = DEN_W - 1;
    localparam int NQ = NM + FRAC_BITS;
    localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [NUM_W-1:0] num_abs;
    logic [DEN_W-1:0] den_abs;

    logic [DM-1:0] rem_reg [0:NQ];
    logic [NQ-1:0] dq_reg  [0:NQ];
    logic [DM-1:0] dv_reg  [0:NQ];
    logic          ng_reg  [0:NQ];

    logic [DM:0]   trial    [1:NQ];
    logic          ge       [1:NQ];
    logic [DM-1:0] rem_next [1:NQ];
    logic [NQ-1:0] dq_next  [1:NQ];

    logic                         q_big;
    logic [COORD_BITS-1:0]        q_low;
    logic signed [COORD_BITS-1:0] quot_next;
    logic signed [COORD_BITS-1:0] quot_reg;

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_abs = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // one quotient bit per stage, restoring
    always_comb begin
        for (int s = 1; s <= NQ; s++) begin
            trial[s]    = {rem_reg[s-1], dq_reg[s-1][NQ-1]};
            ge[s]       = trial[s] >= {1'b0, dv_reg[s-1]};
            rem_next[s] = ge[s] ? DM'(trial[s] - {1'b0, dv_reg[s-1]}) : trial[s][DM-1:0];
            dq_next[s]  = {dq_reg[s-1][NQ-2:0], ge[s]};
        end
    end

    // saturate the magnitude and apply the sign
    always_comb begin
        q_big = dq_reg[NQ] >= (NQ'(1) << (COORD_BITS-1));
        q_low = dq_reg[NQ][COORD_BITS-1:0];
        if (ng_reg[NQ]) begin
            quot_next = q_big ? CMIN : $signed(COORD_BITS'(0) - q_low);
        end else begin
            quot_next = q_big ? CMAX : $signed(q_low);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= NQ'(num_abs[NM-1:0]) << FRAC_BITS;
            dv_reg[0]  <= den_abs[DM-1:0];
            ng_reg[0]  <= num[NUM_W-1] ^ den[DEN_W-1];
            for (int s = 1; s <= NQ; s++) begin
                rem_reg[s] <= rem_next[s];
                dq_reg[s]  <= dq_next[s];
                dv_reg[s]  <= dv_reg[s-1];
                ng_reg[s]  <= ng_reg[s-1];
            end
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

/* design/sbc_point_mul.sv */
`timescale 1ns / 1ps

module sbc_point_mul import sbc_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] base,
    input  logic signed [COORD_BITS:0]   dir,
    input  logic signed [COORD_BITS-1:0] tpar,
    output logic signed [COORD_BITS-1:0] point,
    output logic                         far
);

    localparam int C  = COORD_BITS;
    localparam int H  = C / 2;
    localparam int LW = C - H;
    localparam int PW = 2 * C;
    localparam int PX = (PW > 64) ? PW : 64;
    localparam int OW = PW - FRAC_BITS + 1;
    localparam int SW = ((OW > C) ? OW : C) + 1;
    localparam logic signed [C-1:0] CMAX = {1'b0, {(C-1){1'b1}}};
    localparam logic signed [C-1:0] CMIN = {1'b1, {(C-1){1'b0}}};

    // stage 1: magnitudes
    logic [C-1:0]        uv_reg, ut_reg;
    logic                neg1_reg;
    logic signed [C-1:0] base1_reg;
    // stage 2: partial products
    logic [C+H-1:0]      pl_reg;
    logic [C+LW-1:0]     ph_reg;
    logic                neg2_reg;
    logic signed [C-1:0] base2_reg;
    // stage 3: full product
    logic [PW-1:0]       p_reg;
    logic                neg3_reg;
    logic signed [C-1:0] base3_reg;
    // stage 4: scaled offset
    logic                far4_reg, neg4_reg;
    logic signed [OW-1:0] off4_reg;
    logic signed [C-1:0] base4_reg;
    // stage 5: result
    logic signed [C-1:0] point_reg;
    logic                far_reg;

    logic [C:0]           dir_abs;
    logic [C-1:0]         t_abs;
    logic                 far_next;
    logic [PW:0]          p_round;
    logic [PW:0]          off_mag;
    logic signed [OW-1:0] off_next;
    logic signed [SW-1:0] sum;
    logic signed [C-1:0]  point_next;

    assign dir_abs = dir[C] ? (C+1)'(-dir) : (C+1)'(dir);
    assign t_abs   = tpar[C-1] ? C'(-tpar) : C'(tpar);

    // floor toward minus infinity: round the magnitude up when negative
    always_comb begin
        far_next = PX'(p_reg) > (PX'(1) << PROD_LIMIT_LOG);
        p_round  = (PW+1)'(p_reg) + ((PW+1)'(1) << FRAC_BITS) - (PW+1)'(1);
        off_mag  = neg3_reg ? (p_round >> FRAC_BITS) : ((PW+1)'(p_reg) >> FRAC_BITS);
        off_next = neg3_reg ? -$signed(OW'(off_mag)) : $signed(OW'(off_mag));
    end

    // add to the base and saturate
    always_comb begin
        sum = SW'(base4_reg) + SW'(off4_reg);
        if (far4_reg) begin
            point_next = neg4_reg ? CMIN : CMAX;
        end else if (sum > SW'(CMAX)) begin
            point_next = CMAX;
        end else if (sum < SW'(CMIN)) begin
            point_next = CMIN;
        end else begin
            point_next = C'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            uv_reg    <= dir_abs[C-1:0];
            ut_reg    <= t_abs;
            neg1_reg  <= dir[C] ^ tpar[C-1];
            base1_reg <= base;

            pl_reg    <= (C+H)'(uv_reg) * (C+H)'(ut_reg[H-1:0]);
            ph_reg    <= (C+LW)'(uv_reg) * (C+LW)'(ut_reg[C-1:H]);
            neg2_reg  <= neg1_reg;
            base2_reg <= base1_reg;

            p_reg     <= PW'(pl_reg) + (PW'(ph_reg) << H);
            neg3_reg  <= neg2_reg;
            base3_reg <= base2_reg;

            far4_reg  <= far_next;
            neg4_reg  <= neg3_reg;
            off4_reg  <= off_next;
            base4_reg <= base3_reg;

            point_reg <= point_next;
            far_reg   <= far4_reg;
        end
    end

    assign point = point_reg;
    assign far   = far_reg;

endmodule
